/* hdl/mesh_triangle_assembler_defines.svh */
// assertion macros for the mesh triangle assembler
// expects clk_i and rst_ni in the scope of use
`ifndef MESH_TRIANGLE_ASSEMBLER_DEFINES_SVH
`define MESH_TRIANGLE_ASSEMBLER_DEFINES_SVH

// same-cycle implication
`define MTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mta_pkg.sv */
// types, codes and sizes for the mesh triangle assembler
// no dependencies
package mta_pkg;

  localparam int VERT_DEPTH  = 4096;
  localparam int NORM_DEPTH  = 4096;
  localparam int MAX_CORNERS = 64;
  localparam int VERT_AW     = $clog2(VERT_DEPTH);
  localparam int NORM_AW     = $clog2(NORM_DEPTH);
  localparam int VCNT_W      = $clog2(VERT_DEPTH + 1);
  localparam int NCNT_W      = $clog2(NORM_DEPTH + 1);
  localparam int CC_W        = $clog2(MAX_CORNERS + 1);
  localparam int CNT_W       = 6;
  localparam logic [63:0] TINY_SUM = 64'd1845;

  typedef logic signed [31:0] crd_t;

  typedef struct packed {
    crd_t z;
    crd_t y;
    crd_t x;
  } vec_t;

  typedef struct packed {
    logic [12:0] n;
    logic [11:0] v;
  } corner_t;

  typedef enum logic [1:0] {
    MODE_VERT  = 2'd0,
    MODE_NORM  = 2'd1,
    MODE_FACE  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_VERT = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_RD   = 12'b000000000010,
    S_CAP  = 12'b000000000100,
    S_DIF  = 12'b000000001000,
    S_SH1  = 12'b000000010000,
    S_MUL  = 12'b000000100000,
    S_ABS  = 12'b000001000000,
    S_SH2  = 12'b000010000000,
    S_SQR  = 12'b000100000000,
    S_ROOT = 12'b001000000000,
    S_DIN  = 12'b010000000000,
    S_DIV  = 12'b100000000000
  } state_e;

  function automatic crd_t get_comp(vec_t v, logic [1:0] idx);
    crd_t r;
    case (idx)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      2'd2:    r = v.z;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic vec_t set_comp(vec_t v, logic [1:0] idx, crd_t val);
    vec_t r;
    r = v;
    case (idx)
      2'd0:    r.x = val;
      2'd1:    r.y = val;
      2'd2:    r.z = val;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

/* hdl/mesh_triangle_assembler.sv */
// mesh triangle assembler: vertex and normal tables, fan triangulation, face normals
// depends on mta_pkg and mesh_triangle_assembler_defines.svh
//
// Appends, clears and corners that close no triangle are taken in the idle state. A
// triangle reads its three corners from the tables through the read and capture
// states and, with stored normals, then shows three result words. Without them
// the face normal is worked out by one shared 32x32 multiplier (six cross terms,
// three squares), shift loops of one bit a cycle, a bit-pair square root and a
// restoring divider per component. The tables are not cleared after reset; only
// entries below the fill counts are used.
`include "mesh_triangle_assembler_defines.svh"
module mesh_triangle_assembler import mta_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // coord_x, coord_y, coord_z, vert_index, norm_index, zero fill
  input  logic [127:0] s_axis_tdata_i,
  // corner_last
  input  logic         s_axis_tlast_i,
  // mode
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z
  output logic [191:0] m_axis_tdata_o,
  // triangle_last
  output logic         m_axis_tlast_o,
  // status
  output logic [1:0]   m_axis_tuser_o
);

  state_e              state_q, state_d;
  logic                out_q, out_d;
  logic [VCNT_W-1:0]   vcnt_q, vcnt_d;
  logic [NCNT_W-1:0]   ncnt_q, ncnt_d;
  logic [CC_W-1:0]     cc_q, cc_d;
  corner_t             first_q, first_d, prev_q, prev_d;
  corner_t             k_q [3];
  corner_t             k_d [3];
  status_e             stat_q, stat_d;
  logic                one_q, one_d;
  logic                nok_q, nok_d;
  logic [1:0]          oidx_q, oidx_d;
  logic [1:0]          sub_q, sub_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                shf_q, shf_d;

  vec_t                pos_q [3];
  vec_t                pos_d [3];
  vec_t                nrm_q [3];
  vec_t                nrm_d [3];
  logic [32:0]         md_q [6];
  logic [32:0]         md_d [6];
  logic                sd_q [6];
  logic                sd_d [6];
  logic [63:0]         c_q [3];
  logic [63:0]         c_d [3];
  logic                sc_q [3];
  logic                sc_d [3];
  logic signed [63:0]  prod_q, prod_d;
  logic [63:0]         sum_q, sum_d;
  logic [63:0]         rem_q, rem_d;
  logic [63:0]         root_q, root_d;
  logic [63:0]         bit_q, bit_d;
  logic [47:0]         dnum_q, dnum_d;
  logic [31:0]         drem_q, drem_d;
  logic [31:0]         dquo_q, dquo_d;

  logic [95:0]         vmem [VERT_DEPTH];
  logic [95:0]         nmem [NORM_DEPTH];
  logic [95:0]         vrd_q, nrd_q;
  logic                vwe, nwe;
  logic [VERT_AW-1:0]  vra;
  logic [NORM_AW-1:0]  nra;

  logic                s_acc;
  mode_e               in_mode;
  corner_t             cur;
  vec_t                in_vec;
  logic                vfull, nfull;
  logic signed [31:0]  mul_a, mul_b;

  function automatic logic vbad(corner_t c, logic [VCNT_W-1:0] cnt);
    return 32'(c.v) >= 32'(cnt);
  endfunction

  function automatic logic nvalid(corner_t c, logic [NCNT_W-1:0] cnt);
    return !c.n[12] && (32'(c.n[11:0]) < 32'(cnt));
  endfunction

  function automatic logic signed [31:0] dop(logic [32:0] m, logic s);
    logic [31:0] u;
    u = {2'b00, m[29:0]};
    return s ? $signed(~u + 32'd1) : $signed(u);
  endfunction

  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_mode = mode_e'(s_axis_tuser_i);
  assign cur.v   = s_axis_tdata_i[107:96];
  assign cur.n   = s_axis_tdata_i[120:108];
  assign in_vec  = s_axis_tdata_i[95:0];
  assign vfull   = 32'(vcnt_q) >= VERT_DEPTH;
  assign nfull   = 32'(ncnt_q) >= NORM_DEPTH;

  assign s_axis_tready_o = (state_q == S_IDLE) && !out_q;
  assign m_axis_tvalid_o = out_q;
  assign m_axis_tuser_o  = stat_q;
  assign m_axis_tlast_o  = (stat_q == ST_OK) && (oidx_q == 2'd2);
  assign m_axis_tdata_o  = (stat_q == ST_OK) ? {nrm_q[oidx_q], pos_q[oidx_q]} : '0;

  // table memories
  assign vwe = s_acc && (in_mode == MODE_VERT) && !vfull;
  assign nwe = s_acc && (in_mode == MODE_NORM) && !nfull;
  assign vra = VERT_AW'(k_q[sub_q].v);
  assign nra = NORM_AW'(k_q[sub_q].n[11:0]);

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[vcnt_q[VERT_AW-1:0]] <= in_vec;
    end
    if (nwe) begin
      nmem[ncnt_q[NORM_AW-1:0]] <= in_vec;
    end
    vrd_q <= vmem[vra];
    nrd_q <= nmem[nra];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_MUL) begin
      case (cnt_q[2:0])
        3'd0: begin mul_a = dop(md_q[1], sd_q[1]); mul_b = dop(md_q[5], sd_q[5]); end
        3'd1: begin mul_a = dop(md_q[2], sd_q[2]); mul_b = dop(md_q[4], sd_q[4]); end
        3'd2: begin mul_a = dop(md_q[2], sd_q[2]); mul_b = dop(md_q[3], sd_q[3]); end
        3'd3: begin mul_a = dop(md_q[0], sd_q[0]); mul_b = dop(md_q[5], sd_q[5]); end
        3'd4: begin mul_a = dop(md_q[0], sd_q[0]); mul_b = dop(md_q[4], sd_q[4]); end
        3'd5: begin mul_a = dop(md_q[1], sd_q[1]); mul_b = dop(md_q[3], sd_q[3]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == S_SQR) begin
      case (cnt_q[1:0])
        2'd0: begin mul_a = $signed({1'b0, c_q[0][30:0]}); end
        2'd1: begin mul_a = $signed({1'b0, c_q[1][30:0]}); end
        2'd2: begin mul_a = $signed({1'b0, c_q[2][30:0]}); end
        default: begin mul_a = '0; end
      endcase
      mul_b = mul_a;
    end
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    logic [1:0]  jc;
    logic [2:0]  p;
    crd_t        da, db;
    logic [32:0] diff;
    logic [63:0] snew, tr;
    logic [32:0] tdv;
    logic        qb;
    logic [31:0] qv, nv;

    state_d = state_q;
    out_d   = out_q;
    vcnt_d  = vcnt_q;
    ncnt_d  = ncnt_q;
    cc_d    = cc_q;
    first_d = first_q;
    prev_d  = prev_q;
    k_d     = k_q;
    stat_d  = stat_q;
    one_d   = one_q;
    nok_d   = nok_q;
    oidx_d  = oidx_q;
    sub_d   = sub_q;
    cnt_d   = cnt_q;
    shf_d   = shf_q;
    pos_d   = pos_q;
    nrm_d   = nrm_q;
    md_d    = md_q;
    sd_d    = sd_q;
    c_d     = c_q;
    sc_d    = sc_q;
    sum_d   = sum_q;
    rem_d   = rem_q;
    root_d  = root_q;
    bit_d   = bit_q;
    dnum_d  = dnum_q;
    drem_d  = drem_q;
    dquo_d  = dquo_q;

    jc   = (cnt_q[2:0] < 3'd3) ? cnt_q[1:0] : 2'(cnt_q[2:0] - 3'd3);
    p    = 3'(cnt_q[2:0] - 3'd1);
    da   = get_comp((cnt_q[2:0] < 3'd3) ? pos_q[1] : pos_q[2], jc);
    db   = get_comp(pos_q[0], jc);
    diff = {da[31], da} - {db[31], db};
    snew = sum_q + 64'(prod_q);
    tr   = root_q + bit_q;
    tdv  = {drem_q, dnum_q[47]};
    qb   = tdv >= {1'b0, root_q[31:0]};
    qv   = {dquo_q[30:0], qb};
    nv   = sc_q[sub_q] ? (~qv + 32'd1) : qv;

    if (out_q && m_axis_tready_i) begin
      if (one_q || (oidx_q == 2'd2)) begin
        out_d  = 1'b0;
        oidx_d = '0;
      end else begin
        oidx_d = oidx_q + 2'd1;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          case (in_mode)
            MODE_VERT: begin
              if (vfull) begin
                stat_d = ST_FULL; one_d = 1'b1; oidx_d = '0; out_d = 1'b1;
              end else begin
                vcnt_d = vcnt_q + VCNT_W'(1);
              end
            end
            MODE_NORM: begin
              if (nfull) begin
                stat_d = ST_FULL; one_d = 1'b1; oidx_d = '0; out_d = 1'b1;
              end else begin
                ncnt_d = ncnt_q + NCNT_W'(1);
              end
            end
            MODE_CLEAR: begin
              vcnt_d = '0;
              ncnt_d = '0;
              cc_d   = '0;
            end
            MODE_FACE: begin
              if (32'(cc_q) < MAX_CORNERS) begin
                if (cc_q == '0) begin
                  first_d = cur;
                end else if (cc_q >= CC_W'(2)) begin
                  k_d[0] = first_q;
                  k_d[1] = prev_q;
                  k_d[2] = cur;
                  if (vbad(first_q, vcnt_q) || vbad(prev_q, vcnt_q) || vbad(cur, vcnt_q)) begin
                    stat_d = ST_BAD_VERT; one_d = 1'b1; oidx_d = '0; out_d = 1'b1;
                  end else begin
                    stat_d  = ST_OK;
                    one_d   = 1'b0;
                    nok_d   = nvalid(first_q, ncnt_q) && nvalid(prev_q, ncnt_q) &&
                              nvalid(cur, ncnt_q);
                    sub_d   = '0;
                    state_d = S_RD;
                  end
                end
                prev_d = cur;
                cc_d   = cc_q + CC_W'(1);
              end
              if (s_axis_tlast_i) begin
                cc_d = '0;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD: state_d = S_CAP;
      S_CAP: begin
        pos_d[sub_q] = vrd_q;
        nrm_d[sub_q] = nrd_q;
        if (sub_q == 2'd2) begin
          sub_d = '0;
          cnt_d = '0;
          if (nok_q) begin
            oidx_d  = '0;
            out_d   = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_DIF;
          end
        end else begin
          sub_d   = sub_q + 2'd1;
          state_d = S_RD;
        end
      end
      S_DIF: begin
        md_d[cnt_q[2:0]] = diff[32] ? (~diff + 33'd1) : diff;
        sd_d[cnt_q[2:0]] = diff[32];
        if (cnt_q[2:0] == 3'd5) begin
          cnt_d   = '0;
          shf_d   = 1'b0;
          state_d = S_SH1;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_SH1: begin
        if ((md_q[0][32:30] != '0) || (md_q[1][32:30] != '0) || (md_q[2][32:30] != '0) ||
            (md_q[3][32:30] != '0) || (md_q[4][32:30] != '0) || (md_q[5][32:30] != '0)) begin
          for (int i = 0; i < 6; i++) begin
            md_d[i] = md_q[i] >> 1;
          end
          shf_d = 1'b1;
        end else begin
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (cnt_q[2:0] != 3'd0) begin
          if (!p[0]) begin
            c_d[p[2:1]] = 64'(prod_q);
          end else begin
            c_d[p[2:1]] = c_q[p[2:1]] - 64'(prod_q);
          end
        end
        if (cnt_q[2:0] == 3'd6) begin
          state_d = S_ABS;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_ABS: begin
        for (int i = 0; i < 3; i++) begin
          sc_d[i] = c_q[i][63];
          c_d[i]  = c_q[i][63] ? (~c_q[i] + 64'd1) : c_q[i];
        end
        state_d = S_SH2;
      end
      S_SH2: begin
        if ((c_q[0][63:31] != '0) || (c_q[1][63:31] != '0) || (c_q[2][63:31] != '0)) begin
          for (int i = 0; i < 3; i++) begin
            c_d[i] = c_q[i] >> 1;
          end
          shf_d = 1'b1;
        end else begin
          cnt_d   = '0;
          sum_d   = '0;
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        if (cnt_q[1:0] != 2'd0) begin
          sum_d = snew;
        end
        if (cnt_q[1:0] == 2'd3) begin
          if ((snew == '0) || (!shf_q && (snew < TINY_SUM))) begin
            for (int i = 0; i < 3; i++) begin
              nrm_d[i] = '0;
            end
            oidx_d  = '0;
            out_d   = 1'b1;
            state_d = S_IDLE;
          end else begin
            rem_d   = snew;
            root_d  = '0;
            bit_d   = 64'd1 << 62;
            cnt_d   = '0;
            state_d = S_ROOT;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_ROOT: begin
        if (rem_q >= tr) begin
          rem_d  = rem_q - tr;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (cnt_q == CNT_W'(31)) begin
          sub_d   = '0;
          state_d = S_DIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_DIN: begin
        dnum_d  = {1'b0, c_q[sub_q][30:0], 16'b0} + {17'b0, root_q[31:1]};
        drem_d  = '0;
        dquo_d  = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        drem_d = qb ? 32'(tdv - {1'b0, root_q[31:0]}) : tdv[31:0];
        dquo_d = qv;
        dnum_d = {dnum_q[46:0], 1'b0};
        if (cnt_q == CNT_W'(47)) begin
          for (int i = 0; i < 3; i++) begin
            nrm_d[i] = set_comp(nrm_q[i], sub_q, $signed(nv));
          end
          if (sub_q == 2'd2) begin
            oidx_d  = '0;
            out_d   = 1'b1;
            state_d = S_IDLE;
          end else begin
            sub_d   = sub_q + 2'd1;
            state_d = S_DIN;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_q   <= 1'b0;
      vcnt_q  <= '0;
      ncnt_q  <= '0;
      cc_q    <= '0;
      first_q <= '0;
      prev_q  <= '0;
      stat_q  <= ST_OK;
      one_q   <= 1'b0;
      nok_q   <= 1'b0;
      oidx_q  <= '0;
      sub_q   <= '0;
      cnt_q   <= '0;
      shf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      out_q   <= out_d;
      vcnt_q  <= vcnt_d;
      ncnt_q  <= ncnt_d;
      cc_q    <= cc_d;
      first_q <= first_d;
      prev_q  <= prev_d;
      stat_q  <= stat_d;
      one_q   <= one_d;
      nok_q   <= nok_d;
      oidx_q  <= oidx_d;
      sub_q   <= sub_d;
      cnt_q   <= cnt_d;
      shf_q   <= shf_d;
    end
  end

  // datapath words
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    pos_q  <= pos_d;
    nrm_q  <= nrm_d;
    md_q   <= md_d;
    sd_q   <= sd_d;
    c_q    <= c_d;
    sc_q   <= sc_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    dnum_q <= dnum_d;
    drem_q <= drem_d;
    dquo_q <= dquo_d;
  end

  `MTA_ASSERT_IMP(a_busy_out, m_axis_tvalid_o, !s_axis_tready_o, "input taken while word pending")
  `MTA_ASSERT_IMP(a_err_zero, m_axis_tvalid_o && (m_axis_tuser_o != ST_OK), (m_axis_tdata_o == '0) && !m_axis_tlast_o, "error word carries data")
  `MTA_ASSERT_IMP(a_cnt_rng, 1'b1, (32'(vcnt_q) <= VERT_DEPTH) && (32'(ncnt_q) <= NORM_DEPTH), "table count beyond depth")
  `MTA_ASSERT_NXT(a_last_idle, m_axis_tvalid_o && m_axis_tready_i && (m_axis_tlast_o || (m_axis_tuser_o != ST_OK)), s_axis_tready_o, "not ready after final word")

endmodule
